// ----- hw/rtl/sdw_pkg.sv -----
// Package for the SD card SPI single-block write sequencer.
// Holds phase codes, byte constants, counter sizing and the shared structs.
// No dependencies.
`timescale 1ns / 1ps

package sdw_pkg;

  // Data block size in bytes
  localparam int BLOCK_BYTES = 512;
  localparam int CNT_W = ($clog2(BLOCK_BYTES) > 2) ? $clog2(BLOCK_BYTES) : 2;
  localparam logic [CNT_W-1:0] LAST_PAY = CNT_W'(BLOCK_BYTES - 1);
  localparam logic [CNT_W-1:0] LAST_ARG = CNT_W'(3);

  localparam int PH_W = 5;

  // Sequence phases
  localparam logic [PH_W-1:0] PH_IDLE      = 5'd0;
  localparam logic [PH_W-1:0] PH_POLL_BUSY = 5'd1;
  localparam logic [PH_W-1:0] PH_CMD24     = 5'd2;
  localparam logic [PH_W-1:0] PH_ADDR      = 5'd3;
  localparam logic [PH_W-1:0] PH_CRC_CMD   = 5'd4;
  localparam logic [PH_W-1:0] PH_POLL_R1   = 5'd5;
  localparam logic [PH_W-1:0] PH_TOKEN     = 5'd6;
  localparam logic [PH_W-1:0] PH_PAYLOAD   = 5'd7;
  localparam logic [PH_W-1:0] PH_CRC0      = 5'd8;
  localparam logic [PH_W-1:0] PH_CRC1      = 5'd9;
  localparam logic [PH_W-1:0] PH_POLL_RESP = 5'd10;
  localparam logic [PH_W-1:0] PH_POLL_FF0  = 5'd11;
  localparam logic [PH_W-1:0] PH_POLL_FF1  = 5'd12;
  localparam logic [PH_W-1:0] PH_CMD13     = 5'd13;
  localparam logic [PH_W-1:0] PH_ARG       = 5'd14;
  localparam logic [PH_W-1:0] PH_CRC_STAT  = 5'd15;
  localparam logic [PH_W-1:0] PH_POLL_STAT = 5'd16;

  // Input opcodes
  localparam logic OP_START  = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // Bytes on the wire
  localparam logic [7:0] CMD_PREFIX  = 8'h40;
  localparam logic [7:0] IDLE_BYTE   = 8'hFF;
  localparam logic [7:0] CMD_WRITE   = CMD_PREFIX | 8'd24;
  localparam logic [7:0] CMD_STATUS  = CMD_PREFIX | 8'd13;
  localparam logic [7:0] START_TOKEN = 8'hFE;
  localparam logic [7:0] ZERO_BYTE   = 8'h00;
  localparam logic [4:0] RESP_MASKED = 5'h05;

  typedef struct packed {
    logic [PH_W-1:0]  phase;
    logic [CNT_W-1:0] count;
    logic [31:0]      target;
  } sdw_state_t;

  typedef struct packed {
    logic [7:0]      tx_byte;
    logic            exchange_now;
    logic            select_active;
    logic            payload_taken;
    logic            write_done;
    logic [PH_W-1:0] phase;
  } sdw_result_t;

endpackage

// ----- hw/rtl/sdw_if.sv -----
// Request and result channel interfaces for the write sequencer.
// Depends on sdw_pkg for the phase width.
`timescale 1ns / 1ps

interface sdw_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] block_address;
  logic [7:0]  rx_byte;
  logic [7:0]  payload_byte;

  modport source (output valid, output opcode, output block_address,
                  output rx_byte, output payload_byte, input ready);
  modport sink (input valid, input opcode, input block_address,
                input rx_byte, input payload_byte, output ready);
endinterface

interface sdw_res_if;
  logic                    valid;
  logic                    ready;
  logic [7:0]              tx_byte;
  logic                    exchange_now;
  logic                    select_active;
  logic                    payload_taken;
  logic                    write_done;
  logic [sdw_pkg::PH_W-1:0] phase;

  modport source (output valid, output tx_byte, output exchange_now,
                  output select_active, output payload_taken,
                  output write_done, output phase, input ready);
  modport sink (input valid, input tx_byte, input exchange_now,
                input select_active, input payload_taken,
                input write_done, input phase, output ready);
endinterface

// ----- hw/rtl/sd_spi_block_write_sequencer_core.sv -----
// Top level of the SD card SPI single-block write sequencer.
// A result is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle while the result channel is ready; the single result register sets it,
// refilling in the same cycle its result is taken.
// Reset (rst, synchronous): phase idle, counter and address zero, SDHC off.
// Depends on sdw_pkg, sdw_if, sdw_step and sdw_out_stage.
`timescale 1ns / 1ps

module sd_spi_block_write_sequencer_core (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_write_en,
  input  logic      cfg_write_data,
  sdw_req_if.sink   request,
  sdw_res_if.source result
);
  import sdw_pkg::*;

  logic        card_is_sdhc;
  sdw_state_t  state;
  sdw_state_t  state_next;
  sdw_result_t step_result;
  logic        can_load;
  logic        accept;

  assign request.ready = can_load;
  assign accept        = request.valid && can_load;

  // Hold the addressing mode
  always_ff @(posedge clk) begin
    if (rst) begin
      card_is_sdhc <= 1'b0;
    end else if (cfg_write_en) begin
      card_is_sdhc <= cfg_write_data;
    end
  end

  // Advance the sequence on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  sdw_step u_step (
    .state         (state),
    .card_is_sdhc  (card_is_sdhc),
    .opcode        (request.opcode),
    .block_address (request.block_address),
    .rx_byte       (request.rx_byte),
    .payload_byte  (request.payload_byte),
    .state_next    (state_next),
    .result        (step_result)
  );

  sdw_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .result   (step_result),
    .can_load (can_load),
    .res      (result)
  );

  // An accepted request always leaves a result behind
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> result.valid)
    else $error("no result after accepted request");

  // Completion deselects the card and returns to idle
  a_done_deselects: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.write_done) |->
      (!result.select_active && result.phase == PH_IDLE && state.phase == PH_IDLE))
    else $error("write_done without deselect");

  // Payload is consumed only in the payload phase
  a_payload_phase: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.payload_taken) |-> (result.phase == PH_PAYLOAD))
    else $error("payload taken outside payload phase");

  // The counter never runs past the block size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    state.count <= LAST_PAY || state.count <= LAST_ARG)
    else $error("byte counter out of range");

endmodule

// ----- hw/rtl/sdw_step.sv -----
// Next-state and result logic for one request of the write sequencer.
// Depends on sdw_pkg for phase codes, constants and structs.
`timescale 1ns / 1ps

module sdw_step (
  input  sdw_pkg::sdw_state_t  state,
  input  logic                 card_is_sdhc,
  input  logic                 opcode,
  input  logic [31:0]          block_address,
  input  logic [7:0]           rx_byte,
  input  logic [7:0]           payload_byte,
  output sdw_pkg::sdw_state_t  state_next,
  output sdw_pkg::sdw_result_t result
);
  import sdw_pkg::*;

  logic            r1_ok;
  logic            is_ff;
  logic [PH_W-1:0] p;
  logic [CNT_W-1:0] c;
  logic            abort;
  logic            finish;
  logic [7:0]      addr_byte;

  assign r1_ok = rx_byte inside {8'h00, 8'h01};
  assign is_ff = (rx_byte == IDLE_BYTE);

  // Advance the phase on a completed exchange
  always_comb begin
    p      = state.phase;
    c      = state.count;
    abort  = 1'b0;
    finish = 1'b0;
    case (state.phase)
      PH_POLL_BUSY: begin
        if (is_ff) p = PH_CMD24;
      end
      PH_CMD24: begin
        p = PH_ADDR;
        c = '0;
      end
      PH_ADDR: begin
        if (c < LAST_ARG) c = c + 1'b1;
        else p = PH_CRC_CMD;
      end
      PH_CRC_CMD: p = PH_POLL_R1;
      PH_POLL_R1: begin
        if (r1_ok) p = PH_TOKEN;
      end
      PH_TOKEN: begin
        p = PH_PAYLOAD;
        c = '0;
      end
      PH_PAYLOAD: begin
        if (c < LAST_PAY) c = c + 1'b1;
        else p = PH_CRC0;
      end
      PH_CRC0: p = PH_CRC1;
      PH_CRC1: p = PH_POLL_RESP;
      PH_POLL_RESP: begin
        if (rx_byte[4:0] == RESP_MASKED) p = PH_POLL_FF0;
      end
      PH_POLL_FF0: begin
        if (is_ff) p = PH_POLL_FF1;
      end
      PH_POLL_FF1: begin
        if (is_ff) p = PH_CMD13;
      end
      PH_CMD13: begin
        p = PH_ARG;
        c = '0;
      end
      PH_ARG: begin
        if (c < LAST_ARG) c = c + 1'b1;
        else p = PH_CRC_STAT;
      end
      PH_CRC_STAT: p = PH_POLL_STAT;
      PH_POLL_STAT: begin
        if (r1_ok) finish = 1'b1;
      end
      default: abort = 1'b1;
    endcase
  end

  // Pick the address byte, most significant first
  always_comb begin
    case (c[1:0])
      2'd0:    addr_byte = state.target[31:24];
      2'd1:    addr_byte = state.target[23:16];
      2'd2:    addr_byte = state.target[15:8];
      default: addr_byte = state.target[7:0];
    endcase
  end

  // Build the next state and the result
  always_comb begin
    state_next           = state;
    result.tx_byte       = IDLE_BYTE;
    result.exchange_now  = 1'b1;
    result.select_active = 1'b1;
    result.payload_taken = 1'b0;
    result.write_done    = 1'b0;
    result.phase         = p;
    if (opcode == OP_START) begin
      state_next.target = card_is_sdhc ? {9'd0, block_address[31:9]} : block_address;
      state_next.phase  = PH_POLL_BUSY;
      state_next.count  = '0;
      result.phase      = PH_POLL_BUSY;
    end else if (abort || finish) begin
      state_next.phase     = PH_IDLE;
      state_next.count     = '0;
      result.exchange_now  = finish;
      result.select_active = 1'b0;
      result.write_done    = finish;
      result.phase         = PH_IDLE;
    end else begin
      state_next.phase = p;
      state_next.count = c;
      case (p)
        PH_CMD24:   result.tx_byte = CMD_WRITE;
        PH_ADDR:    result.tx_byte = addr_byte;
        PH_TOKEN:   result.tx_byte = START_TOKEN;
        PH_PAYLOAD: begin
          result.tx_byte       = payload_byte;
          result.payload_taken = 1'b1;
        end
        PH_CMD13:   result.tx_byte = CMD_STATUS;
        PH_ARG:     result.tx_byte = ZERO_BYTE;
        default:    result.tx_byte = IDLE_BYTE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/sdw_out_stage.sv -----
// Result register of the write sequencer, driving the result channel.
// Depends on sdw_pkg for the result struct and on sdw_res_if.
`timescale 1ns / 1ps

module sdw_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  sdw_pkg::sdw_result_t result,
  output logic                 can_load,
  sdw_res_if.source            res
);
  import sdw_pkg::*;

  logic        valid;
  sdw_result_t data;

  // Room when empty or when the held result leaves this cycle
  assign can_load = !valid || res.ready;

  // Hold valid until the result is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (res.ready) begin
      valid <= 1'b0;
    end
  end

  // Capture the result payload
  always_ff @(posedge clk) begin
    if (load) begin
      data <= result;
    end
  end

  assign res.valid         = valid;
  assign res.tx_byte       = data.tx_byte;
  assign res.exchange_now  = data.exchange_now;
  assign res.select_active = data.select_active;
  assign res.payload_taken = data.payload_taken;
  assign res.write_done    = data.write_done;
  assign res.phase         = data.phase;

endmodule
